// File: rtl/stable_level_recalibrator_assert.svh
// assertion helpers for the stable level recalibrator
`ifndef STABLE_LEVEL_RECALIBRATOR_ASSERT_SVH
`define STABLE_LEVEL_RECALIBRATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srl_pkg.sv
`timescale 1ns / 1ps
package srl_pkg;

    localparam int RD_BITS_DEF    = 10;
    localparam int COUNT_BITS     = 8;
    localparam int IDX_BITS       = $clog2(COUNT_BITS);
    localparam int CFG_INDEX_BITS = 3;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_HALF_WIDTH = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUND_LOW_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUND_HIGH_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHECK_INTERVAL    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REQUIRED_SAMPLES  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_LEVEL     = 3'd5;

    // reset values
    localparam int WINDOW_RST   = 5;
    localparam int GROUND_L_RST = 0;
    localparam int GROUND_H_RST = 1023;
    localparam int INTERVAL_RST = 10;
    localparam int REQUIRED_RST = 50;
    localparam int INIT_LVL_RST = 0;

    typedef struct packed {
        logic start;  // latch the reading and arm the remainder unit
        logic step;   // one remainder bit
        logic apply;  // update state and load the result register
    } srl_cmd_t;

    typedef struct packed {
        logic div_last;  // current step is the last remainder bit
    } srl_status_t;

endpackage

// File: rtl/srl_ctrl.sv
`timescale 1ns / 1ps
module srl_ctrl
    import srl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  srl_status_t status,
    output srl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                // wait for the result register to drain
                if (out_free)
                begin
                    cmd.apply      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/srl_dp.sv
`timescale 1ns / 1ps
module srl_dp
    import srl_pkg::*;
#(
    parameter int READING_BITS = RD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [READING_BITS-1:0]   cfg_data,
    input  logic [READING_BITS-1:0]   distance,
    input  srl_cmd_t                  cmd,
    output srl_status_t               status,
    output logic [READING_BITS-1:0]   level,
    output logic                      committed,
    output logic                      searching
);

    localparam int RB = READING_BITS;

    // configuration
    logic [COUNT_BITS-1:0] win_reg;
    logic [RB-1:0]         gnd_low_reg;
    logic [RB-1:0]         gnd_high_reg;
    logic [COUNT_BITS-1:0] interval_reg;
    logic [COUNT_BITS-1:0] required_reg;

    // block state
    logic [RB-1:0]         cal_reg;
    logic [RB-1:0]         cal_next;
    logic [RB-1:0]         ref_reg;
    logic [RB-1:0]         ref_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;

    // per item working registers
    logic [RB-1:0]         rd_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] rem_next;
    logic [IDX_BITS-1:0]   idx_reg;

    // result register
    logic [RB-1:0]         level_reg;
    logic                  committed_reg;
    logic                  committed_next;
    logic                  searching_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= COUNT_BITS'(WINDOW_RST);
            gnd_low_reg  <= RB'(GROUND_L_RST);
            gnd_high_reg <= RB'(GROUND_H_RST);
            interval_reg <= COUNT_BITS'(INTERVAL_RST);
            required_reg <= COUNT_BITS'(REQUIRED_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_HALF_WIDTH: win_reg      <= cfg_data[COUNT_BITS-1:0];
                REG_GROUND_LOW_LIMIT:  gnd_low_reg  <= cfg_data;
                REG_GROUND_HIGH_LIMIT: gnd_high_reg <= cfg_data;
                REG_CHECK_INTERVAL:    interval_reg <= cfg_data[COUNT_BITS-1:0];
                REG_REQUIRED_SAMPLES:  required_reg <= cfg_data[COUNT_BITS-1:0];
                // initial level only matters at reset, where it is back at its reset value
                REG_INITIAL_LEVEL:     ;
                default:               ;
            endcase
        end
    end

    // restoring remainder, one bit of the count per step, msb first
    logic [COUNT_BITS:0] rem_shift;
    logic [COUNT_BITS:0] rem_diff;

    assign rem_shift = {rem_reg, cnt_reg[idx_reg]};
    assign rem_diff  = rem_shift - {1'b0, interval_reg};
    assign rem_next  = (rem_shift >= {1'b0, interval_reg}) ? rem_diff[COUNT_BITS-1:0]
                                                            : rem_shift[COUNT_BITS-1:0];
    assign status.div_last = (idx_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rd_reg  <= distance;
            rem_reg <= '0;
            idx_reg <= IDX_BITS'(COUNT_BITS - 1);
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_reg - 1'b1;
        end
    end

    // inclusive window tests
    logic [RB:0] rd_ext;
    logic [RB:0] rd_plus_w;
    logic [RB:0] cal_plus_w;
    logic [RB:0] ref_plus_w;
    logic        win_cal;
    logic        win_ref;
    logic        idle_match;
    logic        not_ground;
    logic        at_check;

    assign rd_ext     = {1'b0, rd_reg};
    assign rd_plus_w  = rd_ext + (RB+1)'(win_reg);
    assign cal_plus_w = {1'b0, cal_reg} + (RB+1)'(win_reg);
    assign ref_plus_w = {1'b0, ref_reg} + (RB+1)'(win_reg);
    assign win_cal    = (rd_ext <= cal_plus_w) && (rd_plus_w >= {1'b0, cal_reg});
    assign win_ref    = (rd_ext <= ref_plus_w) && (rd_plus_w >= {1'b0, ref_reg});
    assign idle_match = win_cal && (cnt_reg == '0);
    assign not_ground = (rd_reg < gnd_low_reg) || (rd_reg > gnd_high_reg);
    assign at_check   = (interval_reg != '0) && (rem_reg == '0);

    always_comb
    begin
        cal_next       = cal_reg;
        ref_next       = ref_reg;
        cnt_next       = cnt_reg;
        committed_next = 1'b0;
        if (idle_match)
        begin
            // nothing moves
        end
        else if (not_ground)
        begin
            ref_next = '0;
        end
        else if (cnt_reg == '0)
        begin
            ref_next = rd_reg;
            cnt_next = COUNT_BITS'(1);
        end
        else if (at_check)
        begin
            if (!win_ref)
            begin
                ref_next = '0;
                cnt_next = '0;
            end
            else
            begin
                ref_next = rd_reg;
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (cnt_reg >= required_reg)
        begin
            cnt_next = '0;
            if (!win_ref)
            begin
                ref_next = '0;
            end
            else
            begin
                cal_next       = ref_reg;
                committed_next = 1'b1;
            end
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= RB'(INIT_LVL_RST);
            ref_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.apply)
        begin
            cal_reg <= cal_next;
            ref_reg <= ref_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            level_reg     <= cal_next;
            committed_reg <= committed_next;
            searching_reg <= (cnt_next != '0);
        end
    end

    assign level     = level_reg;
    assign committed = committed_reg;
    assign searching = searching_reg;

endmodule

// File: rtl/stable_level_recalibrator.sv
`timescale 1ns / 1ps
// from the input beat to a valid result: 8 remainder steps, then 1 update once the result
//   register is free; a new beat is taken only back in idle; the bit-serial remainder of
//   the sample count by check_interval takes the 8 remainder steps
// reset: asynchronous active low; registers return to their reset values, calibrated level
//   to the initial level reset value, reference and sample count to zero, no result pending
module stable_level_recalibrator
    import srl_pkg::*;
#(
    parameter int READING_BITS = RD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [READING_BITS-1:0]   cfg_data,
    // reading channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [READING_BITS-1:0]   distance,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [READING_BITS-1:0]   level,
    output logic                      committed,
    output logic                      searching
);

`include "stable_level_recalibrator_assert.svh"

    srl_cmd_t    cmd;
    srl_status_t status;

    // register writes are always taken; the user must send them only while the block is idle, which it does not enforce
    assign cfg_ready = 1'b1;

    // sequencer: idle, remainder steps, update and result load
    srl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // registers, block state, remainder unit, decision logic and result register
    srl_dp #(
        .READING_BITS (READING_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .distance  (distance),
        .cmd       (cmd),
        .status    (status),
        .level     (level),
        .committed (committed),
        .searching (searching)
    );

    // a taken beat keeps the block busy for the remainder steps
    `SLR_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready right after beat")

    // a state update always shows up as a pending result
    `SLR_ASSERT_NEXT(a_apply_gives_result, cmd.apply, out_valid, "update without result")

    // a commit always ends the search
    `SLR_ASSERT_SAME(a_commit_ends_search, out_valid && committed, !searching,
                     "commit while still searching")

endmodule
